>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the gyro frame parser modules. Define
// SYNTH to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that prop holds at every rising clk edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");

// Check that cond is never true at a rising clk edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> hdl/gfp_pkg.sv
// ----------------------------------------------------------------------------
// Gyro frame parser package
// Frame geometry, arithmetic constants, status and register codes, and the
// structures passed between the parser stages.
// ----------------------------------------------------------------------------
package gfp_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 16;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  // Bytes 0..14 carry the header and the six measurement words
  localparam int STORE_BYTES = 15;
  localparam int STORE_IDX_W = $clog2(STORE_BYTES);

  localparam logic [7:0] HDR_BYTE = 8'hAA;

  // Yaw compensation constants
  localparam int WRAP_JUMP   = 30000;
  localparam int HALF_CIRCLE = 18000;
  localparam int FULL_CIRCLE = 36000;
  localparam int SCALE_EXTRA = 289;

  // Fraction of the extra scale: q = (r * RECIP_MULT) >> RECIP_SHIFT equals
  // floor(r / FULL_CIRCLE) for every r below 2**FRAC_W.
  localparam int          FRAC_W      = 24;
  localparam int          RECIP_W     = 25;
  localparam int          RECIP_SHIFT = 40;
  localparam int          QUOT_W      = 9;
  localparam logic [24:0] RECIP_MULT  = 25'd30541990;

  // Configuration port
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMP_EN     = 3'd0,
    CFG_STOP_EN     = 3'd1,
    CFG_STOP_TARGET = 3'd2,
    CFG_HALF_TURN   = 3'd3,
    CFG_FULL_TURN   = 3'd4,
    CFG_STOP_TOL    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_GOOD       = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_BAD_SUM    = 2'd2
  } status_t;

  typedef struct packed {
    logic               comp_en;
    logic               stop_en;
    logic signed [15:0] stop_target;
    logic [15:0]        half_turn;
    logic [16:0]        full_turn;
    logic [14:0]        stop_tol;
  } gfp_cfg_t;

  localparam gfp_cfg_t CFG_RESET = '{
    comp_en:     1'b1,
    stop_en:     1'b0,
    stop_target: 16'sd0,
    half_turn:   16'd18000,
    full_turn:   17'd36000,
    stop_tol:    15'd100
  };

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } meas_t;

  typedef struct packed {
    status_t status;
    meas_t   meas;
  } frame_job_t;

  typedef struct packed {
    status_t status;
    meas_t   meas;
    logic    turn_stop_hit;
  } frame_result_t;

endpackage

>>> hdl/gfp_intake.sv
// ----------------------------------------------------------------------------
// Gyro frame byte intake
// Tracks the byte position and running checksum, keeps the header and
// measurement bytes, and issues one frame job on the last byte of a frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfp_intake import gfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  output logic       job_valid,
  output frame_job_t job
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic [7:0]       sum_r, sum_nxt, sum_base;
  logic [7:0]       bytes_r [STORE_BYTES];
  logic             is_last, hdr_ok, store_en;
  status_t          status;
  logic             job_valid_r, job_valid_nxt;
  frame_job_t       job_r, job_nxt;

  always_comb begin
    pos_eff  = frame_start ? '0 : pos_r;
    sum_base = (pos_eff == '0) ? 8'd0 : sum_r;
    is_last  = (pos_eff == LAST_POS);
    store_en = (pos_eff < POS_W'(STORE_BYTES));
    hdr_ok   = (bytes_r[0] == HDR_BYTE) && (bytes_r[1] == HDR_BYTE);

    // header failure takes priority over the checksum
    if (!hdr_ok) begin
      status = ST_BAD_HEADER;
    end else if (sum_base != rx_byte) begin
      status = ST_BAD_SUM;
    end else begin
      status = ST_GOOD;
    end

    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (accept) begin
      if (is_last) begin
        pos_nxt = '0;
        sum_nxt = 8'd0;
      end else begin
        pos_nxt = pos_eff + POS_W'(1);
        sum_nxt = (pos_eff >= POS_W'(2)) ? (sum_base + rx_byte) : sum_base;
      end
    end

    job_valid_nxt        = accept && is_last;
    job_nxt.status       = status;
    job_nxt.meas.yaw     = {bytes_r[4],  bytes_r[3]};
    job_nxt.meas.roll    = {bytes_r[6],  bytes_r[5]};
    job_nxt.meas.pitch   = {bytes_r[8],  bytes_r[7]};
    job_nxt.meas.accel_x = {bytes_r[10], bytes_r[9]};
    job_nxt.meas.accel_y = {bytes_r[12], bytes_r[11]};
    job_nxt.meas.accel_z = {bytes_r[14], bytes_r[13]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sum_r       <= 8'd0;
      job_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_en) begin
      bytes_r[pos_eff[STORE_IDX_W-1:0]] <= rx_byte;
    end
    if (job_valid_nxt) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

  // a job is only issued by the last byte, which wraps the position
  `ASSERT_CLK(a_job_wraps_pos, clk, rst_n, job_valid_r |-> ((pos_r == '0) && $past(accept)))

endmodule

>>> hdl/gfp_yaw_comp.sv
// ----------------------------------------------------------------------------
// Gyro yaw compensation pipeline
// Unwraps yaw with a half-turn counter, scales it by 36289/36000 toward zero
// and folds it back to the half circle, in four register stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfp_yaw_comp import gfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       comp_en,
  input  logic       in_valid,
  input  frame_job_t in_job,
  output logic       out_valid,
  output frame_job_t out_job,
  output logic [2:0] busy_cnt
);

  localparam logic signed [17:0] WRAP_LIM  = 18'(WRAP_JUMP);
  localparam logic signed [16:0] HALF17    = 17'(HALF_CIRCLE);
  localparam logic signed [16:0] FULL17    = 17'(FULL_CIRCLE);
  localparam logic signed [17:0] HALF18    = 18'(HALF_CIRCLE);
  localparam logic signed [17:0] FULL18    = 18'(FULL_CIRCLE);
  localparam logic [FRAC_W-1:0]  SCALE_MUL = FRAC_W'(SCALE_EXTRA);

  // unwrap state
  logic signed [15:0] prev_r;
  logic [7:0]         cnt_r, cnt_nxt;
  logic               upd;
  logic signed [17:0] diff;
  logic signed [16:0] yaw17, yaw_adj;

  // stage registers
  logic               c1_valid_r, c2_valid_r, c3_valid_r, c4_valid_r;
  frame_job_t         c1_job_r, c2_job_r, c3_job_r, c4_job_r, c4_job_nxt;
  logic               c1_comp_r, c2_comp_r, c3_comp_r;
  logic signed [16:0] c1_yaw_r, c2_yaw_r, c3_yaw_r;
  logic [FRAC_W-1:0]  c2_frac_r, frac_nxt;
  logic [QUOT_W-1:0]  c3_q_r, q_nxt;

  logic [16:0]                   mag17;
  logic [FRAC_W+RECIP_W-1:0]     recip_prod;
  logic signed [17:0]            yaw_ext, q_ext, scaled;

  // stage 1: unwrap
  always_comb begin
    upd   = in_valid && (in_job.status == ST_GOOD) && comp_en;
    diff  = {{2{in_job.meas.yaw[15]}}, in_job.meas.yaw} - {{2{prev_r[15]}}, prev_r};
    yaw17 = {in_job.meas.yaw[15], in_job.meas.yaw};

    cnt_nxt = cnt_r;
    if (diff < -WRAP_LIM) begin
      cnt_nxt = cnt_r - 8'd1;
    end else if (diff > WRAP_LIM) begin
      cnt_nxt = cnt_r + 8'd1;
    end

    yaw_adj = yaw17;
    if (comp_en) begin
      if (cnt_nxt[7] && (yaw17 < -HALF17)) begin
        yaw_adj = yaw17 + FULL17;
      end else if (!cnt_nxt[7] && (cnt_nxt != 8'd0) && (yaw17 > HALF17)) begin
        yaw_adj = yaw17 - FULL17;
      end
    end
  end

  // stage 2: extra-scale product on the magnitude
  always_comb begin
    mag17    = c1_yaw_r[16] ? (17'd0 - c1_yaw_r) : c1_yaw_r;
    frac_nxt = {{(FRAC_W-16){1'b0}}, mag17[15:0]} * SCALE_MUL;
  end

  // stage 3: divide the product by the full circle through its reciprocal
  always_comb begin
    recip_prod = {{RECIP_W{1'b0}}, c2_frac_r} * {{FRAC_W{1'b0}}, RECIP_MULT};
    q_nxt      = recip_prod[RECIP_SHIFT +: QUOT_W];
  end

  // stage 4: add the quotient to the magnitude and fold once
  always_comb begin
    yaw_ext = {c3_yaw_r[16], c3_yaw_r};
    q_ext   = {{(18-QUOT_W){1'b0}}, c3_q_r};
    scaled  = c3_yaw_r[16] ? (yaw_ext - q_ext) : (yaw_ext + q_ext);
    if (scaled > HALF18) begin
      scaled = scaled - FULL18;
    end else if (scaled < -HALF18) begin
      scaled = scaled + FULL18;
    end
    c4_job_nxt          = c3_job_r;
    c4_job_nxt.meas.yaw = c3_comp_r ? scaled[15:0] : c3_yaw_r[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= 16'sd0;
      cnt_r      <= 8'd0;
      c1_valid_r <= 1'b0;
      c2_valid_r <= 1'b0;
      c3_valid_r <= 1'b0;
      c4_valid_r <= 1'b0;
    end else begin
      if (upd) begin
        prev_r <= in_job.meas.yaw;
        cnt_r  <= cnt_nxt;
      end
      c1_valid_r <= in_valid;
      c2_valid_r <= c1_valid_r;
      c3_valid_r <= c2_valid_r;
      c4_valid_r <= c3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_job_r  <= in_job;
    c1_yaw_r  <= yaw_adj;
    c1_comp_r <= comp_en;
    c2_job_r  <= c1_job_r;
    c2_yaw_r  <= c1_yaw_r;
    c2_comp_r <= c1_comp_r;
    c2_frac_r <= frac_nxt;
    c3_job_r  <= c2_job_r;
    c3_yaw_r  <= c2_yaw_r;
    c3_comp_r <= c2_comp_r;
    c3_q_r    <= q_nxt;
    c4_job_r  <= c4_job_nxt;
  end

  assign out_valid = c4_valid_r;
  assign out_job   = c4_job_r;
  assign busy_cnt  = {2'b00, c1_valid_r} + {2'b00, c2_valid_r}
                   + {2'b00, c3_valid_r} + {2'b00, c4_valid_r};

  // unwrap state moves only for a good frame with compensation on
  `ASSERT_CLK(a_cnt_hold, clk, rst_n, (cnt_r != $past(cnt_r)) |-> $past(upd))
  // compensated yaw always lands inside the half circle
  `ASSERT_CLK(a_yaw_folded, clk, rst_n, (c3_valid_r && c3_comp_r) |=> ((c4_job_r.meas.yaw >= -16'sd18000) && (c4_job_r.meas.yaw <= 16'sd18000)))

endmodule

>>> hdl/gfp_stop_check.sv
// ----------------------------------------------------------------------------
// Gyro turn stop check and measurement hold
// Keeps the last good measurements and flags yaw within tolerance of the
// stop target for good frames.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfp_stop_check import gfp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  gfp_cfg_t      cfg,
  input  logic          in_valid,
  input  frame_job_t    in_job,
  output logic          res_valid,
  output frame_result_t res
);

  meas_t              held_r;
  logic               good;
  logic signed [16:0] d;
  logic [16:0]        dabs;
  logic signed [17:0] dfold;
  logic               hit;

  always_comb begin
    good = (in_job.status == ST_GOOD);
    d    = {in_job.meas.yaw[15], in_job.meas.yaw} - {cfg.stop_target[15], cfg.stop_target};
    dabs = d[16] ? (17'd0 - d) : d;
    // fold the distance across the turn; it may go negative
    if (dabs > {1'b0, cfg.half_turn}) begin
      dfold = {1'b0, cfg.full_turn} - {1'b0, dabs};
    end else begin
      dfold = {1'b0, dabs};
    end
    hit = cfg.stop_en && good && (dfold < $signed({3'b000, cfg.stop_tol}));

    res.status        = in_job.status;
    res.meas          = good ? in_job.meas : held_r;
    res.turn_stop_hit = hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (in_valid && good) begin
      held_r <= in_job.meas;
    end
  end

  assign res_valid = in_valid;

  // held values change only on a good frame
  `ASSERT_CLK(a_held_on_good, clk, rst_n, (held_r != $past(held_r)) |-> $past(in_valid && (in_job.status == ST_GOOD)))

endmodule

>>> hdl/gfp_out_buf.sv
// ----------------------------------------------------------------------------
// Gyro result output buffer
// Two-entry output register with skid stage for frame results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfp_out_buf import gfp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  frame_result_t push_data,
  input  logic          out_stall,
  output logic          out_valid,
  output frame_result_t out_data,
  output logic [1:0]    count
);

  logic          head_valid_r, head_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  frame_result_t head_r, head_nxt;
  frame_result_t skid_r, skid_nxt;
  logic          pop;

  always_comb begin
    pop            = head_valid_r && !out_stall;
    head_valid_nxt = head_valid_r;
    head_nxt       = head_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        head_nxt       = skid_r;
        skid_valid_nxt = push;
        skid_nxt       = push_data;
      end else begin
        head_valid_nxt = push;
        head_nxt       = push_data;
      end
    end else if (push) begin
      if (head_valid_r) begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = push_data;
      end else begin
        head_valid_nxt = 1'b1;
        head_nxt       = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = head_valid_r;
  assign out_data  = head_r;
  assign count     = {1'b0, head_valid_r} + {1'b0, skid_valid_r};

  `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && skid_valid_r && !pop)
  `ASSERT_CLK(a_skid_behind_head, clk, rst_n, skid_valid_r |-> head_valid_r)

endmodule

>>> hdl/gyro_frame_parser.sv
// ----------------------------------------------------------------------------
// Gyro frame parser
// A result passes the intake job register, the yaw compensation stages and the output buffer head.
// Throughput: one byte per cycle while in_stall is low; one result per frame, and a buffered
// pair may leave back to back. in_stall is high while two results are buffered or in flight.
// Synchronous reset restores register defaults and clears position, checksum,
// yaw unwrap state, held measurements and all pipeline valids.
// ----------------------------------------------------------------------------
module gyro_frame_parser import gfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,

  // byte input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  input  logic                 in_frame_start,

  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_frame_status,
  output logic signed [15:0]   out_yaw_angle,
  output logic signed [15:0]   out_roll_angle,
  output logic signed [15:0]   out_pitch_angle,
  output logic signed [15:0]   out_accel_x,
  output logic signed [15:0]   out_accel_y,
  output logic signed [15:0]   out_accel_z,
  output logic                 out_turn_stop_hit,

  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  gfp_cfg_t      cfg_r, cfg_nxt;
  logic          in_accept;
  logic          job_valid;
  frame_job_t    job;
  logic          comp_valid;
  frame_job_t    comp_job;
  logic [2:0]    comp_busy;
  logic          res_valid;
  frame_result_t res;
  frame_result_t out_data;
  logic [1:0]    buf_cnt;
  logic [2:0]    inflight;

  // Configuration registers. Writes to indexes past the list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_COMP_EN:     cfg_nxt.comp_en     = cfg_wdata[0];
        CFG_STOP_EN:     cfg_nxt.stop_en     = cfg_wdata[0];
        CFG_STOP_TARGET: cfg_nxt.stop_target = cfg_wdata[15:0];
        CFG_HALF_TURN:   cfg_nxt.half_turn   = cfg_wdata[15:0];
        CFG_FULL_TURN:   cfg_nxt.full_turn   = cfg_wdata[16:0];
        CFG_STOP_TOL:    cfg_nxt.stop_tol    = cfg_wdata[14:0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Flow control: the pipeline behind the intake never stalls, so every
  // frame job in flight must already own a slot in the two-entry output
  // buffer. Hold off input once two results are buffered or on their way.
  // Only a last byte can create a job, and jobs are at least a frame apart,
  // so while results drain normally the input never stalls.
  assign inflight  = {2'b00, job_valid} + comp_busy + {1'b0, buf_cnt};
  assign in_stall  = (inflight >= 3'd2);
  assign in_accept = in_valid && !in_stall;

  // Byte intake: position, checksum, byte capture, frame status.
  gfp_intake u_intake (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .rx_byte     (in_rx_byte),
    .frame_start (in_frame_start),
    .job_valid   (job_valid),
    .job         (job)
  );

  // Yaw unwrap, scale and fold while compensation is on; only good frames move the unwrap state.
  gfp_yaw_comp u_yaw_comp (
    .clk       (clk),
    .rst_n     (rst_n),
    .comp_en   (cfg_r.comp_en),
    .in_valid  (job_valid),
    .in_job    (job),
    .out_valid (comp_valid),
    .out_job   (comp_job),
    .busy_cnt  (comp_busy)
  );

  // Turn stop flag and last-good measurement hold.
  gfp_stop_check u_stop_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (comp_valid),
    .in_job    (comp_job),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register plus skid stage toward the result channel.
  gfp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .count     (buf_cnt)
  );

  // Unpack the result transfer onto the field ports.
  assign out_frame_status  = out_data.status;
  assign out_yaw_angle     = out_data.meas.yaw;
  assign out_roll_angle    = out_data.meas.roll;
  assign out_pitch_angle   = out_data.meas.pitch;
  assign out_accel_x       = out_data.meas.accel_x;
  assign out_accel_y       = out_data.meas.accel_y;
  assign out_accel_z       = out_data.meas.accel_z;
  assign out_turn_stop_hit = out_data.turn_stop_hit;

endmodule
